// ===== hdl/bmee_pkg.sv =====
package bmee_pkg;

  localparam int SMP_W = 32;
  localparam int SUM_W = 48;
  localparam int SQ_W  = 64;
  localparam int DIV_W = 16;
  localparam int CFG_W = 16;
  localparam int IDX_W = 8;
  localparam int OUT_W = 32;

  localparam logic [IDX_W-1:0] REG_STEPS = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_LIMIT = IDX_W'(1);

  // One closed block as handed from the front to the back.
  typedef struct packed {
    logic                    clr;
    logic [DIV_W-1:0]        n;
    logic [DIV_W-1:0]        steps;
    logic signed [SUM_W-1:0] sum;
  } blk_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_MEAN,
    ST_MUL_MEAN,
    ST_ACC,
    ST_DIV_AVE,
    ST_DIV_AV2,
    ST_MUL_AVE2,
    ST_SUB,
    ST_DIV_VAR,
    ST_SQRT,
    ST_OUT
  } back_state_e;

endpackage

// ===== hdl/bmee_fifo.sv =====
module bmee_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  bmee_pkg::blk_t  push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output bmee_pkg::blk_t  pop_data_o
);
  import bmee_pkg::*;

  blk_t       mem_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o     = (cnt_q == 2'd2);
  assign valid_o    = (cnt_q != 2'd0);
  assign pop_data_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = ~wr_q;
    end
    if (pop_i) begin
      rd_d = ~rd_q;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

// ===== hdl/bmee_front.sv =====
module bmee_front #(
  parameter int COUNT_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [bmee_pkg::IDX_W-1:0]   cfg_idx_i,
  input  logic [bmee_pkg::CFG_W-1:0]   cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [bmee_pkg::SMP_W-1:0] sample_i,
  input  logic                         restart_i,
  input  logic                         full_i,
  output logic                         push_o,
  output bmee_pkg::blk_t               push_data_o
);
  import bmee_pkg::*;

  logic [COUNT_BITS-1:0]   steps_q, limit_q;
  logic signed [SUM_W-1:0] sum_q, sum_d, sum_b, sum_n;
  logic [COUNT_BITS-1:0]   cnt_q, cnt_d, cnt_b, cnt_n;
  logic [COUNT_BITS-1:0]   bd_q, bd_d, bd_b, bd_inc;
  logic [COUNT_BITS-1:0]   steps_e;
  logic                    pend_q, pend_d, pend_b;
  logic                    acc, close, live;

  assign in_ready_o = !full_i;
  assign acc        = in_valid_i && !full_i;

  always_comb begin
    sum_b   = restart_i ? '0 : sum_q;
    cnt_b   = restart_i ? '0 : cnt_q;
    bd_b    = restart_i ? '0 : bd_q;
    pend_b  = pend_q | restart_i;
    steps_e = (steps_q == '0) ? COUNT_BITS'(1) : steps_q;
    sum_n   = sum_b + SUM_W'(sample_i);
    cnt_n   = cnt_b + COUNT_BITS'(1);
    bd_inc  = bd_b + COUNT_BITS'(1);
    close   = (cnt_n >= steps_e);
    live    = (bd_b < limit_q);

    sum_d  = sum_q;
    cnt_d  = cnt_q;
    bd_d   = bd_q;
    pend_d = pend_q;
    push_o = 1'b0;
    if (acc) begin
      sum_d  = sum_b;
      cnt_d  = cnt_b;
      bd_d   = bd_b;
      pend_d = pend_b;
      if (live) begin
        if (close) begin
          push_o = 1'b1;
          sum_d  = '0;
          cnt_d  = '0;
          bd_d   = bd_inc;
          pend_d = 1'b0;
        end else begin
          sum_d = sum_n;
          cnt_d = cnt_n;
        end
      end
    end

    push_data_o.clr   = pend_b;
    push_data_o.n     = DIV_W'(bd_inc);
    push_data_o.steps = DIV_W'(steps_e);
    push_data_o.sum   = sum_n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steps_q <= COUNT_BITS'(1000);
      limit_q <= COUNT_BITS'(100);
      sum_q   <= '0;
      cnt_q   <= '0;
      bd_q    <= '0;
      pend_q  <= 1'b0;
    end else begin
      if (cfg_we_i && cfg_idx_i == REG_STEPS) begin
        steps_q <= cfg_data_i[COUNT_BITS-1:0];
      end
      if (cfg_we_i && cfg_idx_i == REG_LIMIT) begin
        limit_q <= cfg_data_i[COUNT_BITS-1:0];
      end
      sum_q  <= sum_d;
      cnt_q  <= cnt_d;
      bd_q   <= bd_d;
      pend_q <= pend_d;
    end
  end

endmodule

// ===== hdl/bmee_div.sv =====
module bmee_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [bmee_pkg::SQ_W-1:0]   dividend_i,
  input  logic [bmee_pkg::DIV_W-1:0]  divisor_i,
  output logic                        done_o,
  output logic [bmee_pkg::SQ_W-1:0]   quot_o
);
  import bmee_pkg::*;

  logic [SQ_W-1:0]  q_q;
  logic [DIV_W-1:0] rem_q, d_q;
  logic [5:0]       cnt_q;
  logic             busy_q, done_q;
  logic [DIV_W:0]   rem_sh;
  logic             ge;

  // Restoring division, one quotient bit per cycle.
  assign rem_sh = {rem_q, q_q[SQ_W-1]};
  assign ge     = (rem_sh >= {1'b0, d_q});
  assign done_o = done_q;
  assign quot_o = q_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q   <= dividend_i;
      d_q   <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      q_q   <= {q_q[SQ_W-2:0], ge};
      rem_q <= ge ? DIV_W'(rem_sh - {1'b0, d_q}) : rem_sh[DIV_W-1:0];
    end
  end

endmodule

// ===== hdl/bmee_sqrt.sv =====
module bmee_sqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [bmee_pkg::SQ_W-1:0]  x_i,
  output logic                       done_o,
  output logic [bmee_pkg::OUT_W-1:0] root_o
);
  import bmee_pkg::*;

  logic [SQ_W-1:0] x_q, res_q, bit_q, trial;
  logic            busy_q, done_q;

  // Digit-by-digit root, two radicand bits per cycle.
  assign trial  = res_q + bit_q;
  assign done_o = done_q;
  assign root_o = res_q[OUT_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && bit_q[0]) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= x_i;
      res_q <= '0;
      bit_q <= SQ_W'(1) << (SQ_W - 2);
    end else if (busy_q) begin
      if (x_q >= trial) begin
        x_q   <= x_q - trial;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

endmodule

// ===== hdl/bmee_back.sv =====
module bmee_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              fifo_valid_i,
  input  bmee_pkg::blk_t                    fifo_data_i,
  output logic                              pop_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [bmee_pkg::DIV_W-1:0]        block_index_o,
  output logic signed [bmee_pkg::OUT_W-1:0] block_mean_o,
  output logic signed [bmee_pkg::OUT_W-1:0] running_average_o,
  output logic [bmee_pkg::OUT_W-1:0]        running_error_o
);
  import bmee_pkg::*;

  localparam int HALF_W = SUM_W / 2;
  // Steps of the square: low half, cross term, high half.
  localparam logic [1:0] SQ_LO    = 2'd0;
  localparam logic [1:0] SQ_CROSS = 2'd1;
  localparam logic [1:0] SQ_HI    = 2'd2;

  back_state_e             state_q, state_d;
  blk_t                    ent_q, ent_d;
  logic signed [SQ_W-1:0]  s1_q, s1_d;
  logic [SQ_W-1:0]         s2_q, s2_d;
  logic signed [SUM_W-1:0] mean_q, mean_d, ave_q, ave_d;
  logic [SQ_W-1:0]         prod_q, prod_d, av2_q, av2_d;
  logic [OUT_W-1:0]        err_q, err_d;
  logic [SQ_W-1:0]         dvd_q, dvd_d;
  logic [DIV_W-1:0]        dsr_q, dsr_d;
  logic                    dstart_q, dstart_d, sstart_q, sstart_d;
  logic                    ov_q, ov_d;
  logic [1:0]              mstep_q, mstep_d;
  logic [DIV_W-1:0]        oidx_q;
  logic signed [OUT_W-1:0] omean_q, oave_q;
  logic [OUT_W-1:0]        oerr_q;
  logic                    load;

  logic                    div_done, sqrt_done;
  logic [SQ_W-1:0]         quot;
  logic [OUT_W-1:0]        root;
  logic [SUM_W-1:0]        q48;
  logic [SUM_W-1:0]        mean_mag, ave_mag, sq_src;
  logic [HALF_W-1:0]       sq_hi, sq_lo, mul_a, mul_b;
  logic [SUM_W-1:0]        mul_p;
  logic [SQ_W-1:0]         ave2, var_v;
  logic [SQ_W-1:0]         s1_mag;

  bmee_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (dstart_q),
    .dividend_i (dvd_q),
    .divisor_i  (dsr_q),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  bmee_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sstart_q),
    .x_i     (quot),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  assign q48      = quot[SUM_W-1:0];
  assign mean_mag = mean_q[SUM_W-1] ? (~mean_q + SUM_W'(1)) : mean_q;
  assign ave_mag  = ave_q[SUM_W-1] ? (~ave_q + SUM_W'(1)) : ave_q;
  assign ave2     = prod_q >> 16;
  assign var_v    = (av2_q > ave2) ? (av2_q - ave2) : '0;
  assign load     = (state_q == ST_OUT) && (!ov_q || out_ready_i);

  // Square a magnitude with one half-width multiplier, one partial product at a time,
  // keeping the low 64 bits of the product.
  assign sq_src = (state_q == ST_MUL_MEAN) ? mean_mag : ave_mag;
  assign sq_hi  = sq_src[SUM_W-1:HALF_W];
  assign sq_lo  = sq_src[HALF_W-1:0];
  assign mul_a  = (mstep_q == SQ_LO) ? sq_lo : sq_hi;
  assign mul_b  = (mstep_q == SQ_HI) ? sq_hi : sq_lo;
  assign mul_p  = SUM_W'(mul_a) * SUM_W'(mul_b);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:     if (fifo_valid_i) state_d = ST_DIV_MEAN;
      ST_DIV_MEAN: if (div_done) state_d = ST_MUL_MEAN;
      ST_MUL_MEAN: if (mstep_q == SQ_HI) state_d = ST_ACC;
      ST_ACC:      state_d = ST_DIV_AVE;
      ST_DIV_AVE: begin
        if (div_done) begin
          state_d = (ent_q.n <= DIV_W'(1)) ? ST_OUT : ST_DIV_AV2;
        end
      end
      ST_DIV_AV2:  if (div_done) state_d = ST_MUL_AVE2;
      ST_MUL_AVE2: if (mstep_q == SQ_HI) state_d = ST_SUB;
      ST_SUB:      state_d = ST_DIV_VAR;
      ST_DIV_VAR:  if (div_done) state_d = ST_SQRT;
      ST_SQRT:     if (sqrt_done) state_d = ST_OUT;
      ST_OUT:      if (load) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // Datapath and unit control.
  always_comb begin
    ent_d    = ent_q;
    s1_d     = s1_q;
    s2_d     = s2_q;
    mean_d   = mean_q;
    ave_d    = ave_q;
    prod_d   = prod_q;
    av2_d    = av2_q;
    err_d    = err_q;
    dvd_d    = dvd_q;
    dsr_d    = dsr_q;
    dstart_d = 1'b0;
    sstart_d = 1'b0;
    mstep_d  = SQ_LO;
    pop_o    = 1'b0;
    s1_mag   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (fifo_valid_i) begin
          pop_o    = 1'b1;
          ent_d    = fifo_data_i;
          dvd_d    = SQ_W'(fifo_data_i.sum[SUM_W-1] ? -fifo_data_i.sum : fifo_data_i.sum);
          dsr_d    = fifo_data_i.steps;
          dstart_d = 1'b1;
        end
      end
      ST_DIV_MEAN: begin
        if (div_done) begin
          mean_d = ent_q.sum[SUM_W-1] ? -q48 : q48;
        end
      end
      ST_MUL_MEAN, ST_MUL_AVE2: begin
        if (mstep_q == SQ_LO) begin
          prod_d = SQ_W'(mul_p);
        end else if (mstep_q == SQ_CROSS) begin
          prod_d = prod_q + (SQ_W'(mul_p) << (HALF_W + 1));
        end else begin
          prod_d = prod_q + (SQ_W'(mul_p) << (2 * HALF_W));
        end
        if (mstep_q != SQ_HI) begin
          mstep_d = mstep_q + 2'd1;
        end
      end
      ST_ACC: begin
        s1_d     = (ent_q.clr ? '0 : s1_q) +
                   {{(SQ_W-SUM_W){mean_q[SUM_W-1]}}, mean_q};
        s2_d     = (ent_q.clr ? '0 : s2_q) + (prod_q >> 16);
        s1_mag   = s1_d[SQ_W-1] ? -s1_d : s1_d;
        dvd_d    = s1_mag;
        dsr_d    = ent_q.n;
        dstart_d = 1'b1;
      end
      ST_DIV_AVE: begin
        if (div_done) begin
          ave_d = s1_q[SQ_W-1] ? -q48 : q48;
          err_d = '0;
          if (ent_q.n > DIV_W'(1)) begin
            dvd_d    = s2_q;
            dsr_d    = ent_q.n;
            dstart_d = 1'b1;
          end
        end
      end
      ST_DIV_AV2: begin
        if (div_done) begin
          av2_d = quot;
        end
      end
      ST_SUB: begin
        dvd_d    = var_v << 16;
        dsr_d    = ent_q.n - DIV_W'(1);
        dstart_d = 1'b1;
      end
      ST_DIV_VAR: begin
        if (div_done) begin
          sstart_d = 1'b1;
        end
      end
      ST_SQRT: begin
        if (sqrt_done) begin
          err_d = root;
        end
      end
      ST_OUT: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    ov_d = ov_q;
    if (out_ready_i) begin
      ov_d = 1'b0;
    end
    if (load) begin
      ov_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      s1_q     <= '0;
      s2_q     <= '0;
      dstart_q <= 1'b0;
      sstart_q <= 1'b0;
      ov_q     <= 1'b0;
      mstep_q  <= SQ_LO;
    end else begin
      state_q  <= state_d;
      s1_q     <= s1_d;
      s2_q     <= s2_d;
      dstart_q <= dstart_d;
      sstart_q <= sstart_d;
      ov_q     <= ov_d;
      mstep_q  <= mstep_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q  <= ent_d;
    mean_q <= mean_d;
    ave_q  <= ave_d;
    prod_q <= prod_d;
    av2_q  <= av2_d;
    err_q  <= err_d;
    dvd_q  <= dvd_d;
    dsr_q  <= dsr_d;
    if (load) begin
      oidx_q  <= ent_q.n;
      omean_q <= mean_q[OUT_W-1:0];
      oave_q  <= ave_q[OUT_W-1:0];
      oerr_q  <= err_q;
    end
  end

  assign out_valid_o       = ov_q;
  assign block_index_o     = oidx_q;
  assign block_mean_o      = omean_q;
  assign running_average_o = oave_q;
  assign running_error_o   = oerr_q;

endmodule

// ===== hdl/blocking_mean_error_estimator.sv =====
// Blocking mean and standard-error estimator, signed Q16.16 samples.
//
// Input channel (in_valid_i/in_ready_o): one sample per item, with a restart
// bit that clears all sums and counts before the sample is used. Below the
// block limit the front adds an item per cycle if its 2-entry queue has room.
// Output channel (out_valid_o/out_ready_i): one item per completed block with
// the block index, block mean, running average and its standard error.
// Configuration: cfg_we_i writes register cfg_idx_i (0 block length,
// 1 block limit) at once; write only while the block is idle.
// Work per block: a closed block takes up to four divisions in the back
// on one shared radix-2 divider, one square root and up to two squares;
// the first block skips the error terms.
// Throughput: one sample per cycle while blocks are longer than the back's
// work time; shorter blocks fill the queue and in_ready_o drops.
// Reset: sums, counts and queue clear; block length 1000, block limit 100.
// A stalled receiver holds the result register; the back waits and the queue
// then the front stop in turn, with no item lost.
module blocking_mean_error_estimator #(
  parameter int COUNT_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [bmee_pkg::IDX_W-1:0]        cfg_idx_i,
  input  logic [bmee_pkg::CFG_W-1:0]        cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [bmee_pkg::SMP_W-1:0] sample_i,
  input  logic                              restart_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [bmee_pkg::DIV_W-1:0]        block_index_o,
  output logic signed [bmee_pkg::OUT_W-1:0] block_mean_o,
  output logic signed [bmee_pkg::OUT_W-1:0] running_average_o,
  output logic [bmee_pkg::OUT_W-1:0]        running_error_o
);
  import bmee_pkg::*;

  // Front to queue.
  logic push, full;
  blk_t push_data;
  // Queue to back.
  logic pop, q_valid;
  blk_t pop_data;

  // Accept samples, close blocks and check the block limit.
  bmee_front #(
    .COUNT_BITS (COUNT_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .sample_i    (sample_i),
    .restart_i   (restart_i),
    .full_i      (full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // Hold closed blocks so the front keeps running while the back divides.
  bmee_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .pop_data_o  (pop_data)
  );

  // Divide, update the running sums, take the root and register the result.
  bmee_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .fifo_valid_i      (q_valid),
    .fifo_data_i       (pop_data),
    .pop_o             (pop),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .block_index_o     (block_index_o),
    .block_mean_o      (block_mean_o),
    .running_average_o (running_average_o),
    .running_error_o   (running_error_o)
  );

endmodule
